// ----- hw/rtl/fcct_pkg.sv -----
`timescale 1ns / 1ps

package fcct_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CH_W         = 2;
    localparam int NUM_W        = 11;   // cycles plus kept remainder

    localparam logic [7:0] BIT_IRQ_EN  = 8'h80;
    localparam logic [7:0] BIT_COUNTER = 8'h40;
    localparam logic [7:0] BIT_PRE256  = 8'h20;
    localparam logic [7:0] BIT_LATCH   = 8'h04;
    localparam logic [7:0] BIT_RESET   = 8'h02;
    localparam logic [7:0] BIT_CONTROL = 8'h01;
    localparam logic [7:0] VEC_MASK    = 8'hf8;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] MODE_SINGLE  = 2'd0;
    localparam logic [1:0] MODE_THREE   = 2'd1;
    localparam logic [1:0] MODE_CASCADE = 2'd2;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_OFFSET = 2'd1;
    localparam logic [1:0] CFG_VIDEO  = 2'd2;

    localparam logic [2:0] VIDEO_NONE = 3'd4;

    typedef struct packed {
        logic [7:0] ctrl;
        logic [7:0] reload;
        logic [7:0] count;
        logic       active;
        logic [7:0] cpc;
        logic [7:0] rem;
    } t_chan;

    localparam t_chan CHAN_RST = '{ctrl: 8'h03, reload: 8'd0, count: 8'd0,
                                   active: 1'b0, cpc: 8'd227, rem: 8'd0};

    typedef struct packed {
        t_chan ch;
        logic  zero;
    } t_step;

    typedef enum logic [3:0] {
        S_IDLE, S_WRD, S_WLD, S_VEC, S_TRD3, S_TLD3, S_TRD, S_TLD,
        S_DIV, S_STEP, S_TWB, S_TWB3, S_DONE
    } t_state;

    function automatic logic [7:0] cpc_sel(input logic [1:0] mode, input logic big);
        logic [7:0] r;
        unique case (mode)
            MODE_THREE:   r = big ? 8'd255 : 8'd16;
            MODE_CASCADE: r = big ? 8'd225 : 8'd14;
            default:      r = big ? 8'd245 : 8'd15;
        endcase
        return r;
    endfunction

    function automatic t_chan reload_chan(input t_chan c, input logic is3,
                                          input logic [1:0] mode, input logic [5:0] off);
        t_chan r;
        r = c;
        r.count = c.reload + (is3 ? {{2{off[5]}}, off} : 8'd0);
        r.cpc   = cpc_sel(mode, c.ctrl[5]);
        return r;
    endfunction

    // One count step; zero is set when the counter ran down to zero.
    function automatic t_step step_chan(input t_chan c, input logic is3,
                                        input logic [1:0] mode, input logic [5:0] off);
        t_step r;
        t_chan d;
        d = c;
        r.zero = 1'b0;
        if (c.count != 8'd0) begin
            d.count = c.count - 8'd1;
            if (d.count == 8'd0) begin
                d = reload_chan(d, is3, mode, off);
                r.zero = 1'b1;
            end
        end else begin
            d = reload_chan(d, is3, mode, off);
        end
        r.ch = d;
        return r;
    endfunction

endpackage

// ----- hw/rtl/four_channel_counter_timer_unit.sv -----
`timescale 1ns / 1ps

// Four-channel counter/timer. One request in, one result out. Channel state lives in
// a 4-entry state memory plus a 4-entry vector memory, both with registered reads;
// every request reads them, and writes and ticks modify and write back, one request at a
// time. A vector write on channel 0 writes all four vector entries, one entry a
// cycle. A tick runs, per clocked channel, a read; then, if the channel is active and
// not in counter mode, a bit-serial division of the cycle total by the prescale and
// the counter steps (up to 91 steps); then a write-back. It adds a read and a
// write-back of channel 3 when channel 2 cascades into it.
// Configuration writes are always taken (ready high) and must only come while idle.
module four_channel_counter_timer_unit
    import fcct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [1:0] i_channel,
    input  logic [7:0] i_data_byte,
    input  logic [9:0] i_cpu_cycles,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_value,
    output logic       o_irq_set,
    output logic [7:0] o_irq_vector,
    output logic       o_irq_clear,
    output logic       o_video_vector_valid,
    output logic [7:0] o_video_vector,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // config registers
    logic [1:0] r_mode;
    logic [5:0] r_off;
    logic [2:0] r_vch;

    t_state r_state, n_state;

    // latched request
    logic [1:0]      r_op;
    logic [CH_W-1:0] r_ch;
    logic [7:0]      r_data;
    logic [9:0]      r_cyc;

    // working copies
    t_chan      r_w, r_w3;
    logic [7:0] r_wvec, r_w3vec;

    // divider
    logic [NUM_W-1:0] r_num, r_quo;
    logic [7:0]       r_prem;
    logic [3:0]       r_bit;

    // result accumulation
    logic [7:0] r_rd, r_vec, r_vvec;
    logic       r_irq, r_clr, r_vv;

    // output register
    logic       r_out_valid;
    logic [7:0] r_o_rd, r_o_vec, r_o_vvec;
    logic       r_o_irq, r_o_clr, r_o_vv;

    // memories: state and vectors, with per-entry init bits
    t_chan      mem [NUM_CHANNELS];
    logic [7:0] vmem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_init, r_vinit;
    t_chan      r_rdata;
    logic [7:0] r_rvdata;
    logic       r_rinit, r_rvinit;

    logic [CH_W-1:0] mem_raddr, mem_waddr, vec_waddr;
    logic            mem_we, vec_we;
    t_chan           mem_wdata;
    logic [7:0]      vec_wdata;

    t_chan      rd_chan;
    logic [7:0] rd_vec;

    logic in_acc, out_free, casc, last_ch, div_done;
    logic [CH_W-1:0] first_ch, stop_ch;
    logic [7:0] divisor, prem_n;
    logic [8:0] div_t;
    logic       div_ge;
    t_chan      wr_chan;
    logic       wr_we, wr_vec, wr_clr;
    logic [7:0] d0;
    t_step      st_a, st_b;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign rd_chan = r_rinit  ? r_rdata  : CHAN_RST;
    assign rd_vec  = r_rvinit ? r_rvdata : 8'd0;

    // channels served by a tick
    assign first_ch = (r_mode == MODE_THREE || r_mode == MODE_CASCADE) ? 2'd0 : 2'd1;
    assign stop_ch  = (r_mode == MODE_THREE || r_mode == MODE_CASCADE) ? 2'd2 : 2'd1;
    assign last_ch  = (r_ch == stop_ch);
    assign casc     = (r_mode == MODE_CASCADE) && (r_ch == 2'd2);

    // restoring divider, one quotient bit a cycle
    assign divisor  = (r_w.cpc == 8'd0) ? 8'd1 : r_w.cpc;
    assign div_t    = {r_prem, r_num[NUM_W-1]};
    assign div_ge   = (div_t >= {1'b0, divisor});
    assign prem_n   = div_ge ? 8'(div_t - {1'b0, divisor}) : div_t[7:0];
    assign div_done = (r_bit == 4'(NUM_W - 1));

    // counter steps: the channel itself and, on its zero, cascaded channel 3
    assign st_a = step_chan(r_w, r_ch == 2'd3, r_mode, r_off);
    assign st_b = step_chan(r_w3, 1'b1, r_mode, r_off);

    // byte write decode
    always_comb begin
        d0      = (r_data == 8'd0) ? 8'd255 : r_data;
        wr_chan = rd_chan;
        wr_we   = 1'b0;
        wr_vec  = 1'b0;
        wr_clr  = 1'b0;
        if ((rd_chan.ctrl & BIT_LATCH) != 8'd0) begin
            wr_chan.ctrl   = rd_chan.ctrl & ~BIT_LATCH;
            wr_chan.reload = d0;
            wr_chan.count  = d0;
            wr_chan        = reload_chan(wr_chan, r_ch == 2'd3, r_mode, r_off);
            wr_chan.active = 1'b1;
            wr_we          = 1'b1;
        end else if ((r_data & BIT_CONTROL) != 8'd0) begin
            wr_chan.ctrl   = r_data;
            wr_chan.active = !r_data[1];
            wr_clr         = r_data[1];
            wr_we          = 1'b1;
        end else if (r_ch == 2'd0) begin
            wr_vec = 1'b1;
            wr_clr = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_opcode)
                        OP_WRITE, OP_READ: n_state = S_WRD;
                        OP_TICK: begin
                            n_state = S_TRD;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_WRD: n_state = S_WLD;
            S_WLD: begin
                if (r_op == OP_WRITE && wr_vec) n_state = S_VEC;
                else n_state = S_DONE;
            end
            S_VEC:  n_state = (r_ch == 2'd3) ? S_DONE : S_VEC;
            S_TRD3: n_state = S_TLD3;
            S_TLD3: n_state = S_TRD;
            S_TRD:  n_state = S_TLD;
            S_TLD: begin
                if (!rd_chan.active || (rd_chan.ctrl & BIT_COUNTER) != 8'd0)
                    n_state = S_TWB;
                else
                    n_state = S_DIV;
            end
            S_DIV:  n_state = div_done ? S_STEP : S_DIV;
            S_STEP: n_state = (r_quo == '0) ? S_TWB : S_STEP;
            S_TWB: begin
                priority if (casc) n_state = S_TWB3;
                else if (last_ch) n_state = S_DONE;
                else if (r_mode == MODE_CASCADE && r_ch == 2'd1) n_state = S_TRD3;
                else n_state = S_TRD;
            end
            S_TWB3: n_state = S_DONE;
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        mem_raddr = r_ch;
        mem_we    = 1'b0;
        mem_waddr = r_ch;
        mem_wdata = r_w;
        vec_we    = 1'b0;
        vec_waddr = r_ch;
        vec_wdata = (r_data & VEC_MASK) | {5'd0, r_ch, 1'b0};
        unique case (r_state)
            S_TRD3: mem_raddr = 2'd3;
            S_WLD: begin
                mem_we    = (r_op == OP_WRITE) && wr_we;
                mem_wdata = wr_chan;
            end
            S_VEC: vec_we = 1'b1;
            S_TWB: mem_we = 1'b1;
            S_TWB3: begin
                mem_we    = 1'b1;
                mem_waddr = 2'd3;
                mem_wdata = r_w3;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata  <= mem[mem_raddr];
        r_rvdata <= vmem[mem_raddr];
        r_rinit  <= r_init[mem_raddr];
        r_rvinit <= r_vinit[mem_raddr];
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (vec_we) vmem[vec_waddr] <= vec_wdata;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_SINGLE;
            r_off       <= 6'd0;
            r_vch       <= VIDEO_NONE;
            r_init      <= '0;
            r_vinit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MODE:   r_mode <= i_cfg_data[1:0];
                    CFG_OFFSET: r_off  <= i_cfg_data[5:0];
                    CFG_VIDEO:  r_vch  <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (mem_we) r_init[mem_waddr]  <= 1'b1;
            if (vec_we) r_vinit[vec_waddr] <= 1'b1;
            if (r_state == S_DONE && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall)             r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_op   <= i_opcode;
                    r_ch   <= (i_opcode == OP_TICK) ? first_ch : i_channel;
                    r_data <= i_data_byte;
                    r_cyc  <= i_cpu_cycles;
                    r_rd   <= 8'd0;
                    r_vec  <= 8'd0;
                    r_vvec <= 8'd0;
                    r_irq  <= 1'b0;
                    r_clr  <= 1'b0;
                    r_vv   <= 1'b0;
                end
            end
            S_WLD: begin
                if (r_op == OP_READ) begin
                    r_rd <= rd_chan.count;
                end else begin
                    r_clr <= wr_clr;
                    if (wr_vec && r_vch < VIDEO_NONE) begin
                        r_vv   <= 1'b1;
                        r_vvec <= (r_data & VEC_MASK) | {5'd0, r_vch[1:0], 1'b0};
                    end
                    if (wr_vec) r_ch <= 2'd0;
                end
            end
            S_VEC: r_ch <= r_ch + 2'd1;
            S_TLD3: begin
                r_w3    <= rd_chan;
                r_w3vec <= rd_vec;
            end
            S_TLD: begin
                r_w    <= rd_chan;
                r_wvec <= rd_vec;
                r_num  <= NUM_W'(r_cyc) + NUM_W'(rd_chan.rem);
                r_quo  <= '0;
                r_prem <= 8'd0;
                r_bit  <= 4'd0;
            end
            S_DIV: begin
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_quo  <= {r_quo[NUM_W-2:0], div_ge};
                r_prem <= prem_n;
                r_bit  <= r_bit + 4'd1;
                if (div_done) r_w.rem <= prem_n;
            end
            S_STEP: begin
                if (r_quo != '0) begin
                    r_quo <= r_quo - NUM_W'(1);
                    r_w   <= st_a.ch;
                    if (st_a.zero && r_w.ctrl[7]) begin
                        r_irq <= 1'b1;
                        r_vec <= r_wvec;
                    end
                    if (casc && st_a.zero) begin
                        r_w3 <= st_b.ch;
                        if (st_b.zero && r_w3.ctrl[7]) begin
                            r_irq <= 1'b1;
                            r_vec <= r_w3vec;
                        end
                    end
                end
            end
            S_TWB: begin
                if (!casc && !last_ch) r_ch <= r_ch + 2'd1;
            end
            S_DONE: begin
                if (out_free) begin
                    r_o_rd   <= r_rd;
                    r_o_irq  <= r_irq;
                    r_o_vec  <= r_vec;
                    r_o_clr  <= r_clr;
                    r_o_vv   <= r_vv;
                    r_o_vvec <= r_vvec;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid          = r_out_valid;
    assign o_read_value         = r_o_rd;
    assign o_irq_set            = r_o_irq;
    assign o_irq_vector         = r_o_vec;
    assign o_irq_clear          = r_o_clr;
    assign o_video_vector_valid = r_o_vv;
    assign o_video_vector       = r_o_vvec;

endmodule
